### rtl/core/hsv_pkg.sv
// shared types and constants for the hsv to rgb converter
// no dependencies; imported by every module of the block
package hsv_pkg;

    localparam int unsigned HUE_W   = 13;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned WIDTH_W = 10;

    localparam logic [HUE_W-1:0] HUE_SECTOR = 13'd960;
    localparam logic [HUE_W-1:0] HUE_PERIOD = 13'd1920;

    localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;

    // floor(n/255) for 16-bit n is (n * 0x8081) >> 23
    localparam logic [15:0] RECIP_255 = 16'h8081;
    localparam int unsigned ZC_SHIFT  = 23;

    // floor(n/3825) for n below 2^20 is (n * 1122868) >> 32
    localparam logic [20:0] RECIP_3825 = 21'd1122868;
    localparam int unsigned XC_SHIFT   = 32;

    // sector order: which channel gets chroma and which gets x
    typedef enum logic [2:0] {
        SECT_RED_GRN,
        SECT_GRN_RED,
        SECT_GRN_BLU,
        SECT_BLU_GRN,
        SECT_BLU_RED,
        SECT_RED_BLU
    } t_sector;

    typedef struct packed {
        logic    valid;
        t_sector sector;
    } t_ctl;

endpackage

### rtl/core/hsv_to_rgb_converter_top.sv
// hsv to rgb converter, top level with the channel select output stage
// depends on hsv_pkg, hsv_hue_dec and hsv_chan_calc
//
// usage:
//   input channel: drive i_hue (1/16 degree), i_saturation and i_brightness
//   with i_start high; a beat is taken at each rising edge with i_start high
//   and o_busy low. o_busy never rises, so one beat can enter every cycle.
//   result channel: o_red, o_green and o_blue are valid for exactly one
//   cycle while o_done is high; the receiver cannot hold them off.
//   throughput: one beat per cycle; five register stages (hue decode,
//   small products, numerator and zero-channel reciprocal, x-channel
//   reciprocal, channel select), with at most two multipliers per stage.
//   results leave in the order the beats came in.
//   reset: synchronous, active low; clears every stage valid bit so no
//   result is produced for beats in flight, payload registers are not reset.
//   the receiver has no stall; results leave at the rate beats came in.
module hsv_to_rgb_converter_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic [hsv_pkg::HUE_W-1:0]  i_hue,
    input  logic [hsv_pkg::CHAN_W-1:0] i_saturation,
    input  logic [hsv_pkg::CHAN_W-1:0] i_brightness,
    output logic                       o_done,
    output logic [hsv_pkg::CHAN_W-1:0] o_red,
    output logic [hsv_pkg::CHAN_W-1:0] o_green,
    output logic [hsv_pkg::CHAN_W-1:0] o_blue
);
    import hsv_pkg::*;

    t_ctl               dec_ctl;
    logic [WIDTH_W-1:0] dec_width;
    logic [CHAN_W-1:0]  dec_sat;
    logic [CHAN_W-1:0]  dec_bri;

    t_ctl               calc_ctl;
    logic [CHAN_W-1:0]  calc_xc;
    logic [CHAN_W-1:0]  calc_zc;
    logic [CHAN_W-1:0]  calc_cc;

    logic               r_done;
    logic [CHAN_W-1:0]  r_red;
    logic [CHAN_W-1:0]  r_green;
    logic [CHAN_W-1:0]  r_blue;

    logic [CHAN_W-1:0]  n_red;
    logic [CHAN_W-1:0]  n_green;
    logic [CHAN_W-1:0]  n_blue;

    hsv_hue_dec u_hue_dec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_ctl        (dec_ctl),
        .o_width      (dec_width),
        .o_sat        (dec_sat),
        .o_bri        (dec_bri)
    );

    hsv_chan_calc u_chan_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dec_ctl),
        .i_width (dec_width),
        .i_sat   (dec_sat),
        .i_bri   (dec_bri),
        .o_ctl   (calc_ctl),
        .o_xc    (calc_xc),
        .o_zc    (calc_zc),
        .o_cc    (calc_cc)
    );

    always_comb begin
        case (calc_ctl.sector)
            SECT_RED_GRN: begin
                n_red = calc_cc; n_green = calc_xc; n_blue = calc_zc;
            end
            SECT_GRN_RED: begin
                n_red = calc_xc; n_green = calc_cc; n_blue = calc_zc;
            end
            SECT_GRN_BLU: begin
                n_red = calc_zc; n_green = calc_cc; n_blue = calc_xc;
            end
            SECT_BLU_GRN: begin
                n_red = calc_zc; n_green = calc_xc; n_blue = calc_cc;
            end
            SECT_BLU_RED: begin
                n_red = calc_xc; n_green = calc_zc; n_blue = calc_cc;
            end
            default: begin
                n_red = calc_cc; n_green = calc_zc; n_blue = calc_xc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= calc_ctl.valid;
        end
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
    end

    assign o_busy  = 1'b0;
    assign o_done  = r_done;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    // every accepted beat produces a result on o_done
    a_beat_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##5 o_done)
        else $error("accepted beat produced no result");

    // no result without a matching accepted beat
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && i_rst_n, 5))
        else $error("result without a matching beat");

    // some channel is at least as large as both of the others
    a_chroma_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_red >= o_green && o_red >= o_blue)
                 || (o_green >= o_red && o_green >= o_blue)
                 || (o_blue >= o_red && o_blue >= o_green)))
        else $error("no channel dominates");

endmodule

### rtl/core/hsv_hue_dec.sv
// first pipeline stage: hue sector decode and triangle width w
// depends on hsv_pkg
module hsv_hue_dec (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [hsv_pkg::HUE_W-1:0]   i_hue,
    input  logic [hsv_pkg::CHAN_W-1:0]  i_saturation,
    input  logic [hsv_pkg::CHAN_W-1:0]  i_brightness,
    output hsv_pkg::t_ctl               o_ctl,
    output logic [hsv_pkg::WIDTH_W-1:0] o_width,
    output logic [hsv_pkg::CHAN_W-1:0]  o_sat,
    output logic [hsv_pkg::CHAN_W-1:0]  o_bri
);
    import hsv_pkg::*;

    t_ctl               r_ctl;
    logic [WIDTH_W-1:0] r_width;
    logic [CHAN_W-1:0]  r_sat;
    logic [CHAN_W-1:0]  r_bri;

    t_sector            n_sector;
    logic [10:0]        n_rem;
    logic [WIDTH_W-1:0] n_width;

    // upper sector bound is inclusive
    always_comb begin
        if (i_hue <= HUE_SECTOR) begin
            n_sector = SECT_RED_GRN;
        end else if (i_hue <= 13'(2 * HUE_SECTOR)) begin
            n_sector = SECT_GRN_RED;
        end else if (i_hue <= 13'(3 * HUE_SECTOR)) begin
            n_sector = SECT_GRN_BLU;
        end else if (i_hue <= 13'(4 * HUE_SECTOR)) begin
            n_sector = SECT_BLU_GRN;
        end else if (i_hue <= 13'(5 * HUE_SECTOR)) begin
            n_sector = SECT_BLU_RED;
        end else begin
            n_sector = SECT_RED_BLU;
        end
    end

    // hue mod 1920, hue stays below 5 periods
    always_comb begin
        if (i_hue >= 13'(4 * HUE_PERIOD)) begin
            n_rem = 11'(i_hue - 13'(4 * HUE_PERIOD));
        end else if (i_hue >= 13'(3 * HUE_PERIOD)) begin
            n_rem = 11'(i_hue - 13'(3 * HUE_PERIOD));
        end else if (i_hue >= 13'(2 * HUE_PERIOD)) begin
            n_rem = 11'(i_hue - 13'(2 * HUE_PERIOD));
        end else if (i_hue >= HUE_PERIOD) begin
            n_rem = 11'(i_hue - HUE_PERIOD);
        end else begin
            n_rem = 11'(i_hue);
        end
        if (n_rem >= 11'(HUE_SECTOR)) begin
            n_width = WIDTH_W'(11'(HUE_PERIOD) - n_rem);
        end else begin
            n_width = WIDTH_W'(n_rem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= i_start;
        end
        r_ctl.sector <= n_sector;
        r_width      <= n_width;
        r_sat        <= i_saturation;
        r_bri        <= i_brightness;
    end

    assign o_ctl   = r_ctl;
    assign o_width = r_width;
    assign o_sat   = r_sat;
    assign o_bri   = r_bri;

endmodule

### rtl/core/hsv_chan_calc.sv
// three pipeline stages computing the x, zero and chroma channel values
// depends on hsv_pkg
module hsv_chan_calc (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hsv_pkg::t_ctl               i_ctl,
    input  logic [hsv_pkg::WIDTH_W-1:0] i_width,
    input  logic [hsv_pkg::CHAN_W-1:0]  i_sat,
    input  logic [hsv_pkg::CHAN_W-1:0]  i_bri,
    output hsv_pkg::t_ctl               o_ctl,
    output logic [hsv_pkg::CHAN_W-1:0]  o_xc,
    output logic [hsv_pkg::CHAN_W-1:0]  o_zc,
    output logic [hsv_pkg::CHAN_W-1:0]  o_cc
);
    import hsv_pkg::*;

    // stage a: products of the small factors
    t_ctl              r_a_ctl;
    logic [17:0]       r_a_sw;
    logic [15:0]       r_a_vns;
    logic [17:0]       r_a_ofs;
    logic [CHAN_W-1:0] r_a_bri;

    // stage b: full numerator and zero-channel reciprocal product
    t_ctl              r_b_ctl;
    logic [25:0]       r_b_num;
    logic [31:0]       r_b_zprod;
    logic [CHAN_W-1:0] r_b_bri;

    // stage c: x-channel reciprocal product
    t_ctl              r_c_ctl;
    logic [40:0]       r_c_xprod;
    logic [CHAN_W-1:0] r_c_zc;
    logic [CHAN_W-1:0] r_c_bri;

    logic [CHAN_W-1:0] n_ns;
    logic [17:0]       n_sum;

    assign n_ns  = FULL_SCALE - i_sat;
    assign n_sum = r_a_sw + r_a_ofs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl.valid <= 1'b0;
            r_b_ctl.valid <= 1'b0;
            r_c_ctl.valid <= 1'b0;
        end else begin
            r_a_ctl.valid <= i_ctl.valid;
            r_b_ctl.valid <= r_a_ctl.valid;
            r_c_ctl.valid <= r_b_ctl.valid;
        end
        r_a_ctl.sector <= i_ctl.sector;
        r_b_ctl.sector <= r_a_ctl.sector;
        r_c_ctl.sector <= r_b_ctl.sector;

        r_a_sw  <= 18'(i_sat) * 18'(i_width);
        r_a_vns <= 16'(i_bri) * 16'(n_ns);
        // ns * 960 as ns * 1024 - ns * 64
        r_a_ofs <= {n_ns, 10'b0} - {4'b0, n_ns, 6'b0};
        r_a_bri <= i_bri;

        r_b_num   <= 26'(r_a_bri) * 26'(n_sum);
        r_b_zprod <= 32'(r_a_vns) * 32'(RECIP_255);
        r_b_bri   <= r_a_bri;

        // divide by 255*960: drop 6 bits, then divide by 3825
        r_c_xprod <= 41'(r_b_num[25:6]) * 41'(RECIP_3825);
        r_c_zc    <= r_b_zprod[ZC_SHIFT +: CHAN_W];
        r_c_bri   <= r_b_bri;
    end

    assign o_ctl = r_c_ctl;
    assign o_xc  = r_c_xprod[XC_SHIFT +: CHAN_W];
    assign o_zc  = r_c_zc;
    assign o_cc  = r_c_bri;

endmodule
